@@ design/lcg_next_value_predictor_assert.svh @@
// Assertion macros used by the LCG predictor controller.
`ifndef LCG_NEXT_VALUE_PREDICTOR_ASSERT_SVH
`define LCG_NEXT_VALUE_PREDICTOR_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define LCG_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");
`define LCG_ASSERT_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("forbidden condition seen");
`else
`define LCG_ASSERT(lbl, clk, rstn, prop)
`define LCG_ASSERT_NEVER(lbl, clk, rstn, expr)
`endif
`endif

@@ design/lcgp_pkg.sv @@
// Shared types and constants of the LCG next-value predictor.
package lcgp_pkg;

  localparam int unsigned FIELD_W = 31;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_INV,
    S_LOAD,
    S_MUL,
    S_STORE,
    S_DONE
  } ctl_state_e;

  typedef enum logic [2:0] {
    OP_R0R2,
    OP_R1R1,
    OP_C,
    OP_A,
    OP_P
  } mul_op_e;

  typedef struct packed {
    logic    shift_in;
    logic    start;
    logic    inv_step;
    logic    mul_load;
    logic    mul_step;
    logic    mul_store;
    logic    out_load;
    mul_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic d_odd;
  } dp_sts_t;

endpackage

@@ design/lcgp_dp.sv @@
// Datapath: observation window, bit-serial inverse, radix-4 serial multiplier.
module lcgp_dp #(
  parameter int unsigned W = 31
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  lcgp_pkg::dp_cmd_t                   cmd_i,
  output lcgp_pkg::dp_sts_t                   sts_o,
  input  logic [lcgp_pkg::FIELD_W-1:0]        obs_i,
  output logic [lcgp_pkg::FIELD_W-1:0]        pred_o,
  output logic [lcgp_pkg::FIELD_W-1:0]        mult_o,
  output logic [lcgp_pkg::FIELD_W-1:0]        incr_o,
  output logic                                noinv_o
);
  import lcgp_pkg::*;

  logic [W-1:0] r0_q, r1_q, r2_q;
  logic [W-1:0] x_q, t_q, ds_q, m_q;
  logic [W-1:0] mc_q, b_q, acc_q;
  logic [W-1:0] tmp_q, a_q, c_q, p_q;
  logic         noinv_q;
  logic [FIELD_W+W-1:0] obs_ext;
  logic [W-1:0] obs_w, diff_d, acc_next;
  logic [FIELD_W+W-1:0] p_ext, a_ext, c_ext;

  assign obs_ext  = {{W{1'b0}}, obs_i};
  assign obs_w    = obs_ext[W-1:0];
  assign diff_d   = r0_q - r1_q;
  assign sts_o.d_odd = diff_d[0];
  assign acc_next = acc_q + (b_q[0] ? mc_q : '0) + (b_q[1] ? {mc_q[W-2:0], 1'b0} : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r0_q <= '0;
      r1_q <= '0;
      r2_q <= '0;
    end else if (cmd_i.shift_in) begin
      r0_q <= r1_q;
      r1_q <= r2_q;
      r2_q <= obs_w;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      x_q     <= W'(1);
      t_q     <= diff_d;
      ds_q    <= {diff_d[W-2:0], 1'b0};
      m_q     <= W'(2);
      noinv_q <= ~diff_d[0];
      a_q     <= '0;
      c_q     <= '0;
      p_q     <= '0;
    end else if (cmd_i.inv_step) begin
      // Set this bit of the inverse when the running product shows a one there.
      if (|(t_q & m_q)) begin
        x_q <= x_q | m_q;
        t_q <= t_q + ds_q;
      end
      ds_q <= {ds_q[W-2:0], 1'b0};
      m_q  <= {m_q[W-2:0], 1'b0};
    end

    if (cmd_i.mul_load) begin
      acc_q <= '0;
      case (cmd_i.op)
        OP_R0R2: begin mc_q <= r0_q;        b_q <= r2_q; end
        OP_R1R1: begin mc_q <= r1_q;        b_q <= r1_q; end
        OP_C:    begin mc_q <= tmp_q;       b_q <= x_q;  end
        OP_A:    begin mc_q <= r1_q - r2_q; b_q <= x_q;  end
        default: begin mc_q <= a_q;         b_q <= r2_q; end
      endcase
    end else if (cmd_i.mul_step) begin
      acc_q <= acc_next;
      mc_q  <= {mc_q[W-3:0], 2'b00};
      b_q   <= {2'b00, b_q[W-1:2]};
    end

    if (cmd_i.mul_store) begin
      case (cmd_i.op)
        OP_R0R2: tmp_q <= acc_q;
        OP_R1R1: tmp_q <= tmp_q - acc_q;
        OP_C:    c_q   <= acc_q;
        OP_A:    a_q   <= acc_q;
        default: p_q   <= acc_q + c_q;
      endcase
    end

    if (cmd_i.out_load) begin
      pred_o  <= p_ext[FIELD_W-1:0];
      mult_o  <= a_ext[FIELD_W-1:0];
      incr_o  <= c_ext[FIELD_W-1:0];
      noinv_o <= noinv_q;
    end
  end

  assign p_ext = {{FIELD_W{1'b0}}, p_q};
  assign a_ext = {{FIELD_W{1'b0}}, a_q};
  assign c_ext = {{FIELD_W{1'b0}}, c_q};

endmodule

@@ design/lcgp_ctrl.sv @@
// Controller: fill tracking, step sequencing and output register handshake.
`include "lcg_next_value_predictor_assert.svh"
module lcgp_ctrl #(
  parameter int unsigned W = 31
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output lcgp_pkg::dp_cmd_t cmd_o,
  input  lcgp_pkg::dp_sts_t sts_i
);
  import lcgp_pkg::*;

  localparam int unsigned CW      = $clog2(W);
  localparam int unsigned MUL_CYC = (W + 1) / 2;

  ctl_state_e    state_q, state_d;
  mul_op_e       op_q, op_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [1:0]    fill_q, fill_d;
  logic          ovalid_q, ovalid_d;
  logic          accept, out_free;

  assign accept   = in_valid_i && in_ready_o;
  assign out_free = !ovalid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = ovalid_q;

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    cnt_d   = cnt_q;
    fill_d  = fill_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (fill_q != 2'd3) fill_d = fill_q + 2'd1;
          if (fill_q >= 2'd2) state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        op_d  = OP_R0R2;
        cnt_d = CW'(W - 2);
        state_d = sts_i.d_odd ? S_INV : S_DONE;
      end
      S_INV: begin
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) state_d = S_LOAD;
      end
      S_LOAD: begin
        cnt_d   = CW'(MUL_CYC - 1);
        state_d = S_MUL;
      end
      S_MUL: begin
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) state_d = S_STORE;
      end
      S_STORE: begin
        if (op_q == OP_P) begin
          state_d = S_DONE;
        end else begin
          op_d    = mul_op_e'(op_q + 3'd1);
          state_d = S_LOAD;
        end
      end
      S_DONE: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o           = '0;
    cmd_o.op        = op_q;
    cmd_o.shift_in  = accept;
    cmd_o.start     = (state_q == S_CHECK);
    cmd_o.inv_step  = (state_q == S_INV);
    cmd_o.mul_load  = (state_q == S_LOAD);
    cmd_o.mul_step  = (state_q == S_MUL);
    cmd_o.mul_store = (state_q == S_STORE);
    cmd_o.out_load  = (state_q == S_DONE) && out_free;
  end

  always_comb begin
    ovalid_d = ovalid_q;
    if (out_ready_i) ovalid_d = 1'b0;
    if (cmd_o.out_load) ovalid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      op_q     <= OP_R0R2;
      cnt_q    <= '0;
      fill_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      op_q     <= op_d;
      cnt_q    <= cnt_d;
      fill_q   <= fill_d;
      ovalid_q <= ovalid_d;
    end
  end

  `LCG_ASSERT(a_check_full, clk_i, rst_ni, (state_q == S_CHECK) |-> (fill_q == 2'd3))
  `LCG_ASSERT(a_inv_exit, clk_i, rst_ni, (state_q == S_INV) |=> (state_q == S_INV || state_q == S_LOAD))
  `LCG_ASSERT_NEVER(a_no_overwrite, clk_i, rst_ni, cmd_o.out_load && ovalid_q && !out_ready_i)

endmodule

@@ design/lcg_next_value_predictor.sv @@
// Top level of the LCG next-value predictor: stream ports, controller and datapath.
// Once three observations are held, a new observation is taken only after the result of the last
// is loaded into the output register, so output stalls hold the input; while filling, one a cycle.
// With no inverse the inverse and the products are skipped and the result flags no_inverse.
// The time is set by a bit-serial inverse (one bit a cycle) and five radix-4 serial products.
// Reset is asynchronous and active low; it empties the observation window and the output stage.
module lcg_next_value_predictor #(
  parameter int unsigned MOD_BITS = 31
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,  // [30:0] observed_value, [31] zero pad
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [95:0] m_axis_tdata_o,  // [30:0] predicted_next, [61:31] recovered_multiplier,
                                       // [92:62] recovered_increment, [95:93] zero pad
  output logic [0:0]  m_axis_tuser_o   // [0] no_inverse
);
  import lcgp_pkg::*;

  dp_cmd_t              cmd;
  dp_sts_t              sts;
  logic [FIELD_W-1:0]   pred, mult, incr;
  logic                 noinv;

  // The controller walks each transaction through the check and, for an odd difference, the inverse and the products.
  lcgp_ctrl #(.W(MOD_BITS)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // The datapath holds the window, the results and the output register.
  lcgp_dp #(.W(MOD_BITS)) u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .sts_o   (sts),
    .obs_i   (s_axis_tdata_i[FIELD_W-1:0]),
    .pred_o  (pred),
    .mult_o  (mult),
    .incr_o  (incr),
    .noinv_o (noinv)
  );

  assign m_axis_tdata_o = {3'b000, incr, mult, pred};
  assign m_axis_tuser_o = noinv;

endmodule

@@ tb/lcg_next_value_predictor_tb.sv @@
// Self-checking testbench for the LCG next-value predictor stream block.
`timescale 1ns / 1ps

module lcg_next_value_predictor_tb;

  localparam int unsigned ValW = lcgp_pkg::FIELD_W;
  localparam int unsigned NumRandom = 1850;
  localparam int unsigned QuietTail = 200;
  localparam int unsigned WatchdogLimit = 5000;
  localparam int unsigned SettleCycles = 150;

  typedef logic [ValW-1:0] val_t;

  // One expected output transaction of the block.
  typedef struct packed {
    val_t next_val;
    val_t mult;
    val_t incr;
    logic no_inv;
  } prediction_t;

  // Directed stimulus row; has_golden marks rows whose answer is typed in.
  typedef struct {
    val_t        obs;
    logic        has_golden;
    prediction_t golden;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [31:0] s_axis_tdata_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [95:0] m_axis_tdata_o;
  logic [0:0]  m_axis_tuser_o;

  lcg_next_value_predictor i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // Predictor state: a copy of the observation window and its fill level.
  val_t        window_q [3];
  int unsigned held_cnt;
  prediction_t pending_q[$];
  int unsigned error_cnt;
  int unsigned idle_cnt = 0;
  bit          quiet_mode;

  // Odd inverse modulo 2^ValW by Newton steps; each step doubles correct bits.
  function automatic val_t odd_inverse(val_t d);
    val_t x;
    x = d;
    for (int i = 0; i < 5; i++) begin
      x = x * (val_t'(2) - d * x);
    end
    return x;
  endfunction

  // Shifts one observation into the window and returns whether a
  // prediction follows, along with the prediction itself.
  function automatic bit predict_next(input val_t obs, output prediction_t res);
    val_t r0, r1, r2, d, inv, a, c;
    window_q[0] = window_q[1];
    window_q[1] = window_q[2];
    window_q[2] = obs;
    if (held_cnt < 3) held_cnt++;
    res = '0;
    if (held_cnt < 3) return 1'b0;
    r0 = window_q[0];
    r1 = window_q[1];
    r2 = window_q[2];
    d = r0 - r1;
    if (!d[0]) begin
      res.no_inv = 1'b1;
      return 1'b1;
    end
    inv = odd_inverse(d);
    a = (r1 - r2) * inv;
    c = (r0 * r2 - r1 * r1) * inv;
    res.mult = a;
    res.incr = c;
    res.next_val = a * r2 + c;
    return 1'b1;
  endfunction

  // Sends one observation and records what it should produce.
  task automatic send_obs(input val_t obs, input bit has_golden, input prediction_t golden);
    prediction_t res;
    int unsigned gap;
    if (!quiet_mode && ($urandom_range(0, 3) == 0)) begin
      gap = $urandom_range(1, 13);
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i  <= {1'b0, val_t'($urandom)};
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {1'b0, obs};
    do @(posedge clk_i); while (!s_axis_tready_o);
    if (predict_next(obs, res)) begin
      if (has_golden && (golden != res)) begin
        $error("directed row disagrees with predictor for observation %0h", obs);
        error_cnt++;
      end
      pending_q = {pending_q, res};
    end
  endtask

  // Output side: random stall bursts, compare each transaction in order.
  initial begin
    m_axis_tready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (pending_q.size() == 0) begin
          $error("unexpected output transaction %h", m_axis_tdata_o);
          error_cnt++;
        end else begin
          prediction_t exp_r;
          exp_r = pending_q.pop_front();
          if (m_axis_tdata_o[30:0] !== exp_r.next_val) begin
            $error("predicted_next exp %h got %h", exp_r.next_val, m_axis_tdata_o[30:0]);
            error_cnt++;
          end
          if (m_axis_tdata_o[61:31] !== exp_r.mult) begin
            $error("recovered_multiplier exp %h got %h", exp_r.mult, m_axis_tdata_o[61:31]);
            error_cnt++;
          end
          if (m_axis_tdata_o[92:62] !== exp_r.incr) begin
            $error("recovered_increment exp %h got %h", exp_r.incr, m_axis_tdata_o[92:62]);
            error_cnt++;
          end
          if (m_axis_tuser_o[0] !== exp_r.no_inv) begin
            $error("no_inverse exp %b got %b", exp_r.no_inv, m_axis_tuser_o[0]);
            error_cnt++;
          end
        end
      end
      if (quiet_mode || ($urandom_range(0, 5) != 0)) begin
        m_axis_tready_i <= 1'b1;
      end else begin
        m_axis_tready_i <= 1'b0;
        repeat ($urandom_range(1, 13) - 1) @(posedge clk_i);
      end
    end
  end

  // Watchdog: counts cycles without any accepted transaction.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      idle_cnt <= 0;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

  initial begin
    @(posedge clk_i);
    wait (idle_cnt >= WatchdogLimit);
    $display("lcg_next_value_predictor verification failed");
    $finish;
  end

  stim_row_t   directed_tbl[$];
  prediction_t no_inv_res;

  // Appends one directed row.
  task automatic add_row(input val_t obs, input bit has_golden, input prediction_t golden);
    stim_row_t row;
    row.obs = obs;
    row.has_golden = has_golden;
    row.golden = golden;
    directed_tbl = {directed_tbl, row};
  endtask

  initial begin
    val_t        seq_a, seq_c, seq_x;
    int unsigned seq_len;
    prediction_t dummy;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    rst_ni          = 1'b0;
    error_cnt       = 0;
    held_cnt        = 0;
    quiet_mode      = 1'b0;
    window_q        = '{default: '0};
    dummy           = '0;
    no_inv_res      = '0;
    no_inv_res.no_inv = 1'b1;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Filling: two zeros give no result; the third gives r0 - r1 = 0, even.
    add_row('0, 1'b0, dummy);
    add_row('0, 1'b0, dummy);
    add_row('0, 1'b1, no_inv_res);
    // All ones repeated: the difference is zero, then odd, then zero again.
    add_row('1, 1'b0, dummy);
    add_row('1, 1'b0, dummy);
    add_row('1, 1'b1, no_inv_res);
    // Window 1,1,0 -> difference 0; then 1,0,... -> difference 1, invertible.
    add_row('0, 1'b1, no_inv_res);
    add_row(val_t'(1), 1'b0, dummy);
    add_row(val_t'(2), 1'b0, dummy);
    add_row('1, 1'b0, dummy);
    add_row(val_t'(31'h4000_0000), 1'b0, dummy);
    add_row(val_t'(31'h2AAA_AAAA), 1'b0, dummy);
    add_row(val_t'(31'h5555_5555), 1'b0, dummy);
    add_row('0, 1'b0, dummy);
    add_row('1, 1'b0, dummy);
    add_row(val_t'(31'h1234_5677), 1'b0, dummy);
    add_row(val_t'(31'h7FFF_FFFE), 1'b0, dummy);
    foreach (directed_tbl[i]) begin
      send_obs(directed_tbl[i].obs, directed_tbl[i].has_golden, directed_tbl[i].golden);
    end

    // Hold off the sender once until the output side has drained.
    s_axis_tvalid_i <= 1'b0;
    wait (pending_q.size() == 0);
    @(posedge clk_i);

    // Random part: mostly true generator runs, some raw noise.
    for (int unsigned n = 0; n < NumRandom; ) begin
      if (n > NumRandom - QuietTail) quiet_mode = 1'b1;
      if ($urandom_range(0, 4) == 0) begin
        send_obs(val_t'($urandom), 1'b0, dummy);
        n++;
      end else begin
        seq_a = val_t'($urandom);
        seq_c = val_t'($urandom);
        seq_x = val_t'($urandom);
        seq_len = $urandom_range(3, 12);
        for (int unsigned k = 0; k < seq_len; k++) begin
          send_obs(seq_x, 1'b0, dummy);
          seq_x = seq_a * seq_x + seq_c;
          n++;
        end
      end
    end
    s_axis_tvalid_i <= 1'b0;

    wait (pending_q.size() == 0);
    repeat (SettleCycles) @(posedge clk_i);
    if (error_cnt == 0) begin
      $display("lcg_next_value_predictor verification clean");
    end else begin
      $display("lcg_next_value_predictor verification failed");
    end
    $finish;
  end

endmodule

@@ lcg_next_value_predictor.f @@
+incdir+design
design/lcgp_pkg.sv
design/lcgp_dp.sv
design/lcgp_ctrl.sv
design/lcg_next_value_predictor.sv
tb/lcg_next_value_predictor_tb.sv
